// ===== design/ppc_pkg.sv =====
// Shared types and constants for the PWM prescaler/period calculator.
package ppc_pkg;

  localparam int COUNTER_WIDTH      = 16;
  localparam int DUTY_FRACTION_BITS = 16;
  localparam int FREQ_W             = 32;
  localparam int DUTY_W             = 17;
  localparam int CLK_W              = 32;

  localparam logic [CLK_W-1:0] TIMER_CLOCK_RESET = 32'd120000000;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUTY_W-1:0] duty_fraction;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [COUNTER_WIDTH-1:0] prescaler_minus_one;
    logic [COUNTER_WIDTH-1:0] period_value;
    logic [COUNTER_WIDTH-1:0] compare_value;
  } out_t;

endpackage

// ===== design/ppc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
module ppc_div #(
  parameter int DW = 33,
  parameter int VW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [DW-1:0] in_num,
  input  logic [VW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [DW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic [VW-1:0] rem_r  [DW];
  logic [DW-1:0] nq_r   [DW];
  logic [VW-1:0] den_r  [DW];
  logic [SW-1:0] side_r [DW];
  logic          v_r    [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] rp;
    logic [DW-1:0] np;
    logic [VW-1:0] dp;
    logic [SW-1:0] sp;
    logic          vp;
    logic [VW:0]   t;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rp = '0;
      assign np = in_num;
      assign dp = in_den;
      assign sp = in_side;
      assign vp = in_v;
    end else begin : g_next
      assign rp = rem_r[k-1];
      assign np = nq_r[k-1];
      assign dp = den_r[k-1];
      assign sp = side_r[k-1];
      assign vp = v_r[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign t       = {rp, np[DW-1]};
    assign diff    = t - {1'b0, dp};
    assign ge      = (t >= {1'b0, dp});
    assign rem_nxt = ge ? diff[VW-1:0] : t[VW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= {np[DW-2:0], ge};
        den_r[k]  <= dp;
        side_r[k] <= sp;
      end
    end
  end

  assign out_v    = v_r[DW-1];
  assign out_quot = nq_r[DW-1];
  assign out_side = side_r[DW-1];

endmodule

// ===== design/pwm_prescale_period_calc_core.sv =====
// PWM prescaler/period/compare calculator, top level.
// Usage:
//   in_valid/in_stall/in_data carry a request (frequency in Hz, duty scaled
//   by 2^16). out_valid/out_stall/out_data carry one result per request:
//   status, prescaler minus one, period reload and compare value.
//   cfg_wr_en/cfg_wr_data write the timer clock register (Hz); write it
//   only while no request is in flight.
// Pipeline:
//   One input stage, a 33-stage divider for the cycle count, one
//   prescaler stage, a 34-stage divider for the counts per period, and
//   three stages for clamp, duty multiply and rounding. One request is
//   taken every cycle while out_stall does not hold a waiting result.
// Reset: synchronous, active low; clears all valid bits and loads the
//   clock register with 120 MHz.
// Stall: when out_stall holds a waiting result, the whole pipeline freezes
//   and in_stall is raised in the same cycle; nothing is lost or repeated.
module pwm_prescale_period_calc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ppc_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ppc_pkg::out_t         out_data,
  input  logic                  cfg_wr_en,
  input  logic [ppc_pkg::CLK_W-1:0] cfg_wr_data
);

  localparam int CW    = ppc_pkg::COUNTER_WIDTH;
  localparam int DFB   = ppc_pkg::DUTY_FRACTION_BITS;
  localparam int DTW   = ppc_pkg::DUTY_W;
  localparam int FW    = ppc_pkg::FREQ_W;
  localparam int N1W   = ppc_pkg::CLK_W + 1;
  localparam int N2W   = N1W + 1;
  localparam int PSW   = CW + 1;
  localparam int S1W   = 1 + DTW;
  localparam int S2W   = 2 + PSW + DTW;
  localparam int PRW   = CW + DTW;
  localparam logic [N1W-1:0] SPAN_M1 = N1W'((64'd1 << CW) - 64'd1);
  localparam logic [N1W-1:0] SPAN1   = N1W'(64'd1 << CW);
  localparam logic [N2W-1:0] SPAN2   = N2W'(64'd1 << CW);
  localparam logic [PRW:0]   HALF    = (PRW+1)'(64'd1 << (DFB - 1));

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // timer clock register
  logic [ppc_pkg::CLK_W-1:0] tclk_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tclk_r <= ppc_pkg::TIMER_CLOCK_RESET;
    end else if (cfg_wr_en) begin
      tclk_r <= cfg_wr_data;
    end
  end

  // stage A: rounded dividend for clock / frequency
  logic           a_v_r;
  logic [N1W-1:0] a_num_r;
  logic [FW-1:0]  a_den_r;
  logic [S1W-1:0] a_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_num_r  <= {1'b0, tclk_r} + {2'b0, in_data.frequency_hz[FW-1:1]};
      a_den_r  <= in_data.frequency_hz;
      a_side_r <= {(in_data.frequency_hz == '0), in_data.duty_fraction};
    end
  end

  logic           d1_v;
  logic [N1W-1:0] d1_q;
  logic [S1W-1:0] d1_side;
  ppc_div #(.DW(N1W), .VW(FW), .SW(S1W)) u_div_cyc (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(a_v_r), .in_num(a_num_r), .in_den(a_den_r), .in_side(a_side_r),
    .out_v(d1_v), .out_quot(d1_q), .out_side(d1_side)
  );

  // stage B: prescaler and rounded dividend for cycles / prescaler
  logic [N1W-1:0] cyc;
  logic [N1W-1:0] psc_sum;
  logic [N1W-1:0] psc_full;
  logic [1:0]     b_st;
  assign cyc      = (d1_q == '0) ? N1W'(1) : d1_q;
  assign psc_sum  = cyc + SPAN_M1;
  assign psc_full = psc_sum >> CW;
  always_comb begin
    priority if (d1_side[S1W-1]) b_st = ppc_pkg::STATUS_INVALID;
    else if (psc_full > SPAN1)   b_st = ppc_pkg::STATUS_RANGE;
    else                         b_st = ppc_pkg::STATUS_OK;
  end

  logic           b_v_r;
  logic [N2W-1:0] b_num_r;
  logic [PSW-1:0] b_den_r;
  logic [S2W-1:0] b_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= d1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_num_r  <= {1'b0, cyc} + {1'b0, (psc_full >> 1)};
      b_den_r  <= psc_full[PSW-1:0];
      b_side_r <= {b_st, psc_full[PSW-1:0], d1_side[DTW-1:0]};
    end
  end

  logic           d2_v;
  logic [N2W-1:0] d2_q;
  logic [S2W-1:0] d2_side;
  ppc_div #(.DW(N2W), .VW(PSW), .SW(S2W)) u_div_cnt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(b_v_r), .in_num(b_num_r), .in_den(b_den_r), .in_side(b_side_r),
    .out_v(d2_v), .out_quot(d2_q), .out_side(d2_side)
  );

  // stage C: clamp counts, derive period
  logic [N2W-1:0] cnt;
  logic [N2W-1:0] per_full;
  logic [PSW-1:0] psc_m1;
  always_comb begin
    priority if (d2_q < N2W'(2)) cnt = N2W'(2);
    else if (d2_q > SPAN2)       cnt = SPAN2;
    else                         cnt = d2_q;
  end
  assign per_full = cnt - N2W'(1);
  assign psc_m1   = d2_side[DTW +: PSW] - PSW'(1);

  logic           c_v_r;
  logic [1:0]     c_st_r;
  logic [CW-1:0]  c_psc_r;
  logic [CW-1:0]  c_per_r;
  logic [DTW-1:0] c_duty_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= d2_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_st_r   <= d2_side[S2W-1 -: 2];
      c_psc_r  <= psc_m1[CW-1:0];
      c_per_r  <= per_full[CW-1:0];
      c_duty_r <= d2_side[DTW-1:0];
    end
  end

  // stage D: period times duty
  logic           d_v_r;
  logic [1:0]     d_st_r;
  logic [CW-1:0]  d_psc_r;
  logic [CW-1:0]  d_per_r;
  logic [PRW-1:0] d_prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_st_r   <= c_st_r;
      d_psc_r  <= c_psc_r;
      d_per_r  <= c_per_r;
      d_prod_r <= PRW'(c_per_r) * PRW'(c_duty_r);
    end
  end

  // stage E: round, clamp, zero on error; output register
  logic [PRW:0]  rnd;
  logic [PRW:0]  cmp_full;
  logic [CW-1:0] cmp;
  assign rnd      = {1'b0, d_prod_r} + HALF;
  assign cmp_full = rnd >> DFB;
  assign cmp      = (cmp_full > (PRW+1)'(d_per_r)) ? d_per_r : cmp_full[CW-1:0];

  logic          e_v_r;
  ppc_pkg::out_t e_out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_out_r.status <= d_st_r;
      if (d_st_r == ppc_pkg::STATUS_OK) begin
        e_out_r.prescaler_minus_one <= d_psc_r;
        e_out_r.period_value        <= d_per_r;
        e_out_r.compare_value       <= cmp;
      end else begin
        e_out_r.prescaler_minus_one <= '0;
        e_out_r.period_value        <= '0;
        e_out_r.compare_value       <= '0;
      end
    end
  end

  assign out_valid = e_v_r;
  assign out_data  = e_out_r;

endmodule

// ===== design/ppc_check.sv =====
// Port-level assertions for the PWM calculator, bound to the top level.
module ppc_check (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input ppc_pkg::in_t          in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input ppc_pkg::out_t         out_data,
  input logic                  cfg_wr_en,
  input logic [ppc_pkg::CLK_W-1:0] cfg_wr_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input stalls only when the output holds a waiting result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // error results carry zero settings
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ppc_pkg::STATUS_OK |->
      out_data.prescaler_minus_one == '0 && out_data.period_value == '0 &&
      out_data.compare_value == '0)
    else $error("error result with nonzero settings");

  // good results: compare within period, period nonzero
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ppc_pkg::STATUS_OK |->
      out_data.compare_value <= out_data.period_value &&
      out_data.period_value != '0)
    else $error("compare above period or zero period");

endmodule

bind pwm_prescale_period_calc_core ppc_check u_ppc_check (.*);

// ===== bench/pwm_prescale_period_calc_core_tb.sv =====
// Testbench for the PWM prescaler/period/compare calculator core.
module pwm_prescale_period_calc_core_tb;

  localparam int LATENCY = 72;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ppc_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  ppc_pkg::out_t out_data;
  logic cfg_wr_en;
  logic [ppc_pkg::CLK_W-1:0] cfg_wr_data;

  int error_count;
  int sent_count;
  int checked_count;
  int idle_cycles;
  bit quiet_tail;
  bit hold_request;

  // Expected timer settings for one request under a given timer clock.
  function automatic ppc_pkg::out_t timer_settings(logic [ppc_pkg::CLK_W-1:0] clk_hz,
                                                   ppc_pkg::in_t req);
    ppc_pkg::out_t res;
    logic [63:0] cycles, psc, counts, period, cmp;
    logic [63:0] span;
    span = 64'd1 << ppc_pkg::COUNTER_WIDTH;
    res = '0;
    if (req.frequency_hz == 0) begin
      res.status = ppc_pkg::STATUS_INVALID;
      return res;
    end
    cycles = (64'(clk_hz) + 64'(req.frequency_hz >> 1)) / 64'(req.frequency_hz);
    if (cycles == 0) cycles = 1;
    psc = (cycles + span - 1) / span;
    if (psc == 0) psc = 1;
    if (psc > span) begin
      res.status = ppc_pkg::STATUS_RANGE;
      return res;
    end
    counts = (cycles + (psc >> 1)) / psc;
    if (counts < 2) counts = 2;
    else if (counts > span) counts = span;
    period = counts - 1;
    cmp = (period * 64'(req.duty_fraction) +
           (64'd1 << (ppc_pkg::DUTY_FRACTION_BITS - 1))) >> ppc_pkg::DUTY_FRACTION_BITS;
    if (cmp > period) cmp = period;
    res.status = ppc_pkg::STATUS_OK;
    res.prescaler_minus_one = 16'(psc - 1);
    res.period_value = 16'(period);
    res.compare_value = 16'(cmp);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Scoreboard: holds expected results in transfer order.
  class settings_board;
    ppc_pkg::out_t pending[$];
    logic [ppc_pkg::CLK_W-1:0] clock_hz;

    function void note_request(ppc_pkg::in_t req);
      pending.push_back(timer_settings(clock_hz, req));
    endfunction

    task check_result(ppc_pkg::out_t got);
      ppc_pkg::out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.status), 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.prescaler_minus_one !== want.prescaler_minus_one)
        report_mismatch("prescaler", 32'(got.prescaler_minus_one),
                        32'(want.prescaler_minus_one));
      if (got.period_value !== want.period_value)
        report_mismatch("period", 32'(got.period_value), 32'(want.period_value));
      if (got.compare_value !== want.compare_value)
        report_mismatch("compare", 32'(got.compare_value), 32'(want.compare_value));
    endtask
  endclass

  settings_board board;

  pwm_prescale_period_calc_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: random stall bursts, a long hold-off on request, none at the tail.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result check and watchdog on accepted transfers.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        board.check_result(out_data);
        checked_count++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results pending", board.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one request and wait until it is transferred.
  task automatic send_request(logic [31:0] freq, logic [16:0] duty);
    ppc_pkg::in_t req;
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.frequency_hz = freq;
    req.duty_fraction = duty;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    board.note_request(req);
    sent_count++;
  endtask

  task automatic drain_and_write_clock(logic [ppc_pkg::CLK_W-1:0] clk_hz);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= clk_hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.clock_hz = clk_hz;
  endtask

  function automatic logic [31:0] random_freq(logic [ppc_pkg::CLK_W-1:0] clk_hz);
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 2000);
      1: return $urandom_range(1, 200000);
      2: return $urandom;
      3: return (clk_hz >> $urandom_range(0, 31)) + $urandom_range(0, 3) - 1;
      4: return clk_hz / $urandom_range(1, 70000);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [16:0] random_duty();
    case ($urandom_range(0, 3))
      0: return 17'($urandom_range(0, 65536));
      1: return 17'($urandom);
      2: return 17'(32768 + $urandom_range(0, 2) - 1);
      default: return ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
    endcase
  endfunction

  initial begin
    logic [ppc_pkg::CLK_W-1:0] clock_plan[6];
    board = new();
    board.clock_hz = ppc_pkg::TIMER_CLOCK_RESET;
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    idle_cycles = 0;
    quiet_tail = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset, zero and full-scale clocks, field extremes, zero frequency, duty above one.
    send_request(32'd0, 17'd32768);
    send_request(32'd1, 17'd0);
    send_request(32'd1, 17'd65536);
    send_request(32'hFFFF_FFFF, 17'h1FFFF);
    send_request(32'd1000, 17'd32768);
    send_request(32'd1831, 17'd65535);
    send_request(32'd1832, 17'd1);
    send_request(32'd20000, 17'd100000);
    send_request(32'd60000000, 17'd32768);
    send_request(32'd120000000, 17'd65536);
    send_request(32'd240000001, 17'd16384);
    drain_and_write_clock(32'd0);
    send_request(32'd1, 17'd32768);
    send_request(32'd0, 17'd0);
    send_request(32'd5, 17'h1FFFF);
    drain_and_write_clock(32'hFFFF_FFFF);
    send_request(32'd1, 17'd32768);
    send_request(32'd1, 17'h1FFFF);
    send_request(32'd65536, 17'd65535);
    send_request(32'hFFFF_FFFF, 17'd32768);
    send_request(32'h7FFF_FFFF, 17'd3);

    // Random phases over several clock settings, extremes among them.
    clock_plan[0] = 32'd1;
    clock_plan[1] = ppc_pkg::TIMER_CLOCK_RESET;
    clock_plan[2] = $urandom;
    clock_plan[3] = 32'd65536;
    clock_plan[4] = 32'hFFFF_FFFF;
    clock_plan[5] = 32'd240000000;
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write_clock(clock_plan[ph]);
      if (ph == 2) hold_request = 1'b1;
      if (ph == 5) quiet_tail = 1'b1;
      for (int k = 0; k < 140; k++)
        send_request(random_freq(clock_plan[ph]), random_duty());
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Covered %0d requests, %0d results, over nine timer clock phases",
             sent_count, checked_count);
    $display("including zero and full-scale clocks, zero frequency and saturated duty");
    if (error_count == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== pwm_prescale_period_calc_core.f =====
design/ppc_pkg.sv
design/ppc_div.sv
design/pwm_prescale_period_calc_core.sv
design/ppc_check.sv
bench/pwm_prescale_period_calc_core_tb.sv
